// ----- hdl/cttok_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cttok_pkg
// Shared types, codes and character constants of the configuration text
// tokenizer.
// ----------------------------------------------------------------------------
package cttok_pkg;

  localparam int unsigned MaxTokenLen = 511;
  localparam int unsigned LenW        = 9;
  localparam int unsigned LineW       = 16;
  localparam int unsigned MaxResults  = 3;
  localparam int unsigned SlotW       = 2;
  localparam int unsigned FifoDepth   = 8;
  localparam int unsigned FifoAw      = 3;
  localparam int unsigned FifoCntW    = 4;

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChEq     = 8'h3D;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChN      = 8'h6E;

  typedef enum logic [2:0] {
    ModeSkip,
    ModeComment,
    ModeQuote,
    ModeQesc,
    ModeFold,
    ModeBare,
    ModeBesc,
    ModeHalt
  } mode_e;

  typedef enum logic [1:0] {
    OutByte      = 2'd0,
    OutTokEnd    = 2'd1,
    OutStreamEnd = 2'd2,
    OutError     = 2'd3
  } out_kind_e;

  typedef enum logic [2:0] {
    ErrEofQuote   = 3'd0,
    ErrBadEscape  = 3'd1,
    ErrNlQuote    = 3'd2,
    ErrQuoteLong  = 3'd3,
    ErrEscEof     = 3'd4,
    ErrTokenLong  = 3'd5
  } err_e;

  // one result as it leaves the block
  typedef struct packed {
    out_kind_e        out_kind;
    logic [7:0]       token_byte;
    err_e             error_code;
    logic [LineW-1:0] line_number;
    logic             last;
  } result_t;

  // results caused by one item, slot 0 first
  typedef struct packed {
    logic [SlotW-1:0]               n;
    result_t [MaxResults-1:0]       res;
  } batch_t;

  typedef struct packed {
    out_kind_e  kind;
    logic [7:0] tbyte;
    err_e       code;
  } ev_t;

  function automatic logic is_nl(logic [7:0] c);
    return (c == ChLf) || (c == ChCr);
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || is_nl(c);
  endfunction

  function automatic ev_t mk_ev(out_kind_e kind, logic [7:0] tbyte, err_e code);
    ev_t e;
    e.kind  = kind;
    e.tbyte = tbyte;
    e.code  = code;
    return e;
  endfunction

endpackage

// ----- hdl/cttok_lex.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cttok_lex
// Input register, lexer state and the combinational step that turns one
// input beat into up to three results.
// ----------------------------------------------------------------------------
module cttok_lex import cttok_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  logic   in_kind_i,
  input  logic [7:0] in_byte_i,
  input  logic   room_i,
  output logic   wr_en_o,
  output batch_t batch_o
);

  logic             in_valid_q;
  logic             in_kind_q;
  logic [7:0]       in_byte_q;
  logic             fire;

  mode_e            mode_q, mode_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [LineW-1:0] line_q, line_d;
  logic             herr_q, herr_d;
  err_e             hcode_q, hcode_d;

  ev_t [MaxResults-1:0] ev;
  logic [SlotW-1:0]     slot;

  assign fire       = in_valid_q && room_i;
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_kind_q <= in_kind_i;
      in_byte_q <= in_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeSkip;
      len_q   <= '0;
      line_q  <= '0;
      herr_q  <= 1'b0;
      hcode_q <= ErrEofQuote;
    end else if (fire) begin
      mode_q  <= mode_d;
      len_q   <= len_d;
      line_q  <= line_d;
      herr_q  <= herr_d;
      hcode_q <= hcode_d;
    end
  end

  // next state and raw events
  always_comb begin
    logic       eof;
    logic [7:0] c;
    logic       skip_run;
    logic       quote_run;
    logic       quote_after;
    logic       qstore;
    logic [7:0] qval;

    eof         = in_kind_q;
    c           = in_byte_q;
    skip_run    = 1'b0;
    quote_run   = 1'b0;
    quote_after = 1'b0;
    qstore      = 1'b0;
    qval        = ChSpace;
    mode_d      = mode_q;
    len_d       = len_q;
    line_d      = line_q;
    herr_d      = herr_q;
    hcode_d     = hcode_q;
    slot        = '0;
    ev          = '0;

    unique case (mode_q)
      ModeSkip: begin
        skip_run = 1'b1;
      end
      ModeComment: begin
        if (eof) begin
          ev[slot] = mk_ev(OutStreamEnd, '0, ErrEofQuote);
          slot     = slot + 2'd1;
          mode_d   = ModeHalt;
          herr_d   = 1'b0;
          len_d    = '0;
        end else if (is_nl(c)) begin
          if (line_q != '1) line_d = line_q + 1'b1;
          mode_d = ModeSkip;
        end
      end
      ModeQuote: begin
        quote_run = 1'b1;
      end
      ModeQesc: begin
        if (eof) begin
          ev[slot] = mk_ev(OutError, '0, ErrBadEscape);
          slot     = slot + 2'd1;
          mode_d   = ModeHalt;
          herr_d   = 1'b1;
          hcode_d  = ErrBadEscape;
        end else if (c == ChQuote || c == ChBslash) begin
          mode_d = ModeQuote;
          qstore = 1'b1;
          qval   = c;
        end else if (is_nl(c)) begin
          mode_d = ModeFold;
        end else if (c == ChN) begin
          mode_d = ModeQuote;
          qstore = 1'b1;
          qval   = ChLf;
        end else begin
          ev[slot] = mk_ev(OutError, '0, ErrBadEscape);
          slot     = slot + 2'd1;
          mode_d   = ModeHalt;
          herr_d   = 1'b1;
          hcode_d  = ErrBadEscape;
        end
      end
      ModeFold: begin
        // blanks after a folded newline are eaten, a nul is dropped silently
        if (eof || !(c == ChSpace || c == ChTab)) begin
          mode_d = ModeQuote;
          if (eof || c != ChNul) begin
            qstore      = 1'b1;
            qval        = ChSpace;
            quote_after = 1'b1;
          end
        end
      end
      ModeBare: begin
        if (len_q >= LenW'(MaxTokenLen)) begin
          ev[slot] = mk_ev(OutError, '0, ErrTokenLong);
          slot     = slot + 2'd1;
          mode_d   = ModeHalt;
          herr_d   = 1'b1;
          hcode_d  = ErrTokenLong;
        end else if (eof || is_blank(c) || c == ChHash || c == ChEq) begin
          // terminator closes the token and is handled again between tokens
          ev[slot] = mk_ev(OutTokEnd, '0, ErrEofQuote);
          slot     = slot + 2'd1;
          mode_d   = ModeSkip;
          skip_run = 1'b1;
        end else if (c == ChBslash) begin
          mode_d = ModeBesc;
        end else begin
          ev[slot] = mk_ev(OutByte, c, ErrEofQuote);
          slot     = slot + 2'd1;
          len_d    = len_q + 1'b1;
        end
      end
      ModeBesc: begin
        if (len_q >= LenW'(MaxTokenLen)) begin
          ev[slot] = mk_ev(OutError, '0, ErrTokenLong);
          slot     = slot + 2'd1;
          mode_d   = ModeHalt;
          herr_d   = 1'b1;
          hcode_d  = ErrTokenLong;
        end else if (eof) begin
          ev[slot] = mk_ev(OutError, '0, ErrEscEof);
          slot     = slot + 2'd1;
          mode_d   = ModeHalt;
          herr_d   = 1'b1;
          hcode_d  = ErrEscEof;
        end else begin
          if (c == ChLf) begin
            if (line_q != '1) line_d = line_q + 1'b1;
          end else begin
            ev[slot] = mk_ev(OutByte, (c == ChTab) ? ChSpace : c, ErrEofQuote);
            slot     = slot + 2'd1;
            len_d    = len_q + 1'b1;
          end
          mode_d = ModeBare;
        end
      end
      ModeHalt: begin
        if (herr_q) ev[slot] = mk_ev(OutError, '0, hcode_q);
        else        ev[slot] = mk_ev(OutStreamEnd, '0, ErrEofQuote);
        slot = slot + 2'd1;
      end
    endcase

    if (qstore) begin
      ev[slot] = mk_ev(OutByte, qval, ErrEofQuote);
      slot     = slot + 2'd1;
      len_d    = len_d + 1'b1;
      if (len_d >= LenW'(MaxTokenLen)) begin
        ev[slot] = mk_ev(OutError, '0, ErrQuoteLong);
        slot     = slot + 2'd1;
        mode_d   = ModeHalt;
        herr_d   = 1'b1;
        hcode_d  = ErrQuoteLong;
      end
      quote_run = quote_after && (mode_d == ModeQuote);
    end

    if (quote_run) begin
      if (eof) begin
        ev[slot] = mk_ev(OutError, '0, ErrEofQuote);
        slot     = slot + 2'd1;
        mode_d   = ModeHalt;
        herr_d   = 1'b1;
        hcode_d  = ErrEofQuote;
      end else if (c == ChQuote) begin
        ev[slot] = mk_ev(OutTokEnd, '0, ErrEofQuote);
        slot     = slot + 2'd1;
        mode_d   = ModeSkip;
      end else if (c == ChBslash) begin
        mode_d = ModeQesc;
      end else if (is_nl(c)) begin
        ev[slot] = mk_ev(OutError, '0, ErrNlQuote);
        slot     = slot + 2'd1;
        mode_d   = ModeHalt;
        herr_d   = 1'b1;
        hcode_d  = ErrNlQuote;
      end else begin
        ev[slot] = mk_ev(OutByte, c, ErrEofQuote);
        slot     = slot + 2'd1;
        len_d    = len_d + 1'b1;
        if (len_d >= LenW'(MaxTokenLen)) begin
          ev[slot] = mk_ev(OutError, '0, ErrQuoteLong);
          slot     = slot + 2'd1;
          mode_d   = ModeHalt;
          herr_d   = 1'b1;
          hcode_d  = ErrQuoteLong;
        end
      end
    end

    if (skip_run) begin
      if (eof || c == ChNul) begin
        ev[slot] = mk_ev(OutStreamEnd, '0, ErrEofQuote);
        slot     = slot + 2'd1;
        mode_d   = ModeHalt;
        herr_d   = 1'b0;
        len_d    = '0;
      end else if (is_blank(c)) begin
        if (is_nl(c) && line_q != '1) line_d = line_q + 1'b1;
      end else if (c == ChHash) begin
        mode_d = ModeComment;
      end else if (c == ChEq) begin
        ev[slot]         = mk_ev(OutByte, ChEq, ErrEofQuote);
        ev[slot + 2'd1]  = mk_ev(OutTokEnd, '0, ErrEofQuote);
        slot             = slot + 2'd2;
      end else if (c == ChQuote) begin
        mode_d = ModeQuote;
        len_d  = '0;
      end else if (c == ChBslash) begin
        mode_d = ModeBesc;
        len_d  = '0;
      end else begin
        ev[slot] = mk_ev(OutByte, c, ErrEofQuote);
        slot     = slot + 2'd1;
        mode_d   = ModeBare;
        len_d    = LenW'(1);
      end
    end
  end

  // every result carries the line count from before the step
  always_comb begin
    wr_en_o   = fire;
    batch_o.n = slot;
    for (int i = 0; i < MaxResults; i++) begin
      batch_o.res[i].out_kind    = ev[i].kind;
      batch_o.res[i].token_byte  = ev[i].tbyte;
      batch_o.res[i].error_code  = ev[i].code;
      batch_o.res[i].line_number = line_q;
      batch_o.res[i].last        = (SlotW'(i) + 2'd1 == slot);
    end
  end

endmodule

// ----- hdl/cttok_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cttok_fifo
// Result queue: takes up to three results per cycle, hands out one per
// cycle while the reader is ready.
// ----------------------------------------------------------------------------
module cttok_fifo import cttok_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_en_i,
  input  batch_t  batch_i,
  output logic    room_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t data_o
);

  result_t             mem [FifoDepth];
  logic [FifoAw-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FifoAw-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic [SlotW-1:0]    n_wr;
  logic                pop;

  assign n_wr    = wr_en_i ? batch_i.n : '0;
  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign data_o  = mem[rd_ptr_q];
  // room for a full three-result burst
  assign room_o  = (cnt_q <= FifoCntW'(FifoDepth - MaxResults));

  always_comb begin
    wr_ptr_d = wr_ptr_q + FifoAw'(n_wr);
    rd_ptr_d = rd_ptr_q + FifoAw'(pop);
    cnt_d    = cnt_q + FifoCntW'(n_wr) - FifoCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxResults; i++) begin
      if (SlotW'(i) < n_wr) begin
        mem[wr_ptr_q + FifoAw'(i)] <= batch_i.res[i];
      end
    end
  end

endmodule

// ----- hdl/config_text_tokenizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// config_text_tokenizer
// Byte-level lexer for key=value configuration text: one text byte or end
// mark per beat in, token bytes, token ends, stream end and errors out.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                                  tuser        tlast
//  s_axis    in   [7:0] text byte                        [0] kind     -
//  m_axis    out  [7:0] token byte, [10:8] error code,   [1:0] kind   last result
//                 [26:11] line number, [31:27] zero                   of the item
//
// one input beat is taken per cycle while there is room; an input register feeds
// a combinational lex step that writes up to three results into an eight-entry
// output queue. the step fires only while the queue has room for three results,
// so a stalled output side backs up into s_axis_tready after a few beats. results
// leave at one per cycle while m_axis_tready is high; an item with two or three
// results holds the sustained rate below one item per cycle while it drains.
// reset is asynchronous and active low and returns the lexer to between tokens.
// ----------------------------------------------------------------------------
module config_text_tokenizer import cttok_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tuser,   // [0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] token_byte, [10:8] error_code,
                                      // [26:11] line_number, [31:27] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] out_kind
  output logic        m_axis_tlast    // last
);

  logic    room;
  logic    wr_en;
  batch_t  batch;
  result_t head;

  cttok_lex u_lex (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_kind_i  (s_axis_tuser),
    .in_byte_i  (s_axis_tdata),
    .room_i     (room),
    .wr_en_o    (wr_en),
    .batch_o    (batch)
  );

  cttok_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (wr_en),
    .batch_i (batch),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (head)
  );

  assign m_axis_tdata = {5'd0, head.line_number, head.error_code, head.token_byte};
  assign m_axis_tuser = head.out_kind;
  assign m_axis_tlast = head.last;

endmodule
